// File: hdl/wrwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrist raise wake detector package
// Shared types, constants and field layouts for the detector core.
// ----------------------------------------------------------------------------
package wrwd_pkg;

   localparam int REQUIRED_STABLE_DEF = 2;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [31:0] RUN_BLOCK_MS      = 32'd900;
   localparam logic [31:0] GESTURE_WINDOW_MS = 32'd1800;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 18;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RUN_ACCEL    = 3'd0,
      CSR_RUN_GYRO     = 3'd1,
      CSR_GEST_ACCEL   = 3'd2,
      CSR_GEST_GYRO    = 3'd3,
      CSR_GEST_SCORE   = 3'd4,
      CSR_STABLE_ACCEL = 3'd5,
      CSR_STABLE_GYRO  = 3'd6,
      CSR_COOLDOWN     = 3'd7
   } csr_index_type;

   localparam logic [17:0] RUN_ACCEL_RST    = 18'd9500;
   localparam logic [16:0] RUN_GYRO_RST     = 17'd26000;
   localparam logic [17:0] GEST_ACCEL_RST   = 18'd900;
   localparam logic [16:0] GEST_GYRO_RST    = 17'd2600;
   localparam logic [17:0] GEST_SCORE_RST   = 18'd2400;
   localparam logic [17:0] STABLE_ACCEL_RST = 18'd950;
   localparam logic [16:0] STABLE_GYRO_RST  = 17'd3600;
   localparam logic [15:0] COOLDOWN_RST     = 16'd4000;

   typedef enum logic [2:0] {
      REASON_NONE     = 3'd0,
      REASON_RUNNING  = 3'd1,
      REASON_CAND     = 3'd2,
      REASON_EXPIRED  = 3'd3,
      REASON_WOKE     = 3'd4,
      REASON_DISARMED = 3'd5
   } reason_type;

   // Input word, last member in the lowest bits.
   typedef struct packed {
      logic signed [15:0] gyro_z;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_x;
      logic signed [15:0] accel_z;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_x;
      logic [31:0]        timestamp_ms;
      logic               armed;
   } req_word_type;

   // Result word, last member in the lowest bits.
   typedef struct packed {
      logic [1:0]  stable_count;
      logic        candidate_active;
      logic [17:0] activity_score;
      logic [16:0] gyro_magnitude;
      logic [17:0] accel_change;
      reason_type  reason;
      logic        wake;
   } rsp_word_type;

   // Entry passed from the front end to the decision stage.
   typedef struct packed {
      logic        armed;
      logic [31:0] now;
      logic [17:0] change;
      logic [16:0] gsum;
      logic [17:0] score;
   } metrics_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

endpackage

// File: hdl/wrwd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrist raise wake detector front end
// Accepts samples and computes accel change, gyro sum and motion score.
// ----------------------------------------------------------------------------
module wrwd_front
   import wrwd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_word_type  in_word,
   input  logic          q_full,
   output logic          q_push,
   output metrics_type   q_entry
);

   logic signed [15:0] prev_accel_ff [3];
   logic signed [15:0] prev_accel_in [3];
   logic               have_prev_ff;
   logic               have_prev_in;

   logic signed [15:0] cur_accel [3];
   logic signed [15:0] cur_gyro  [3];
   logic        [15:0] adiff [3];
   logic        [15:0] gabs  [3];
   logic        [17:0] change_sum;
   logic        [16:0] gyro_total;
   logic               accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign q_push   = accept;

   assign cur_accel[0] = in_word.accel_x;
   assign cur_accel[1] = in_word.accel_y;
   assign cur_accel[2] = in_word.accel_z;
   assign cur_gyro[0]  = in_word.gyro_x;
   assign cur_gyro[1]  = in_word.gyro_y;
   assign cur_gyro[2]  = in_word.gyro_z;

   always_comb begin
      logic signed [16:0] d;
      for (int i = 0; i < 3; i++) begin
         d = 17'(cur_accel[i]) - 17'(prev_accel_ff[i]);
         adiff[i] = d[16] ? 16'(-d) : d[15:0];
         d = 17'(cur_gyro[i]);
         gabs[i] = d[16] ? 16'(-d) : d[15:0];
      end
      change_sum = 18'(adiff[0]) + 18'(adiff[1]) + 18'(adiff[2]);
      gyro_total = 17'(gabs[0]) + 17'(gabs[1]) + 17'(gabs[2]);
   end

   always_comb begin
      q_entry.armed  = in_word.armed;
      q_entry.now    = in_word.timestamp_ms;
      q_entry.change = '0;
      q_entry.gsum   = '0;
      q_entry.score  = '0;
      // Metrics stay zero on the first sample after arming.
      if (in_word.armed && have_prev_ff) begin
         q_entry.change = change_sum;
         q_entry.gsum   = gyro_total;
         q_entry.score  = change_sum + 18'(gyro_total[16:1]);
      end
   end

   always_comb begin
      have_prev_in  = have_prev_ff;
      prev_accel_in = prev_accel_ff;
      if (accept) begin
         have_prev_in = in_word.armed;
         if (in_word.armed) begin
            prev_accel_in = cur_accel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            prev_accel_ff[i] <= '0;
         end
      end else begin
         have_prev_ff  <= have_prev_in;
         prev_accel_ff <= prev_accel_in;
      end
   end

endmodule

// File: hdl/wrwd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrist raise wake detector queue
// Short FIFO of metric words between the front end and the decision stage.
// ----------------------------------------------------------------------------
module wrwd_queue
   import wrwd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  queue_ctl_type ctl_in,
   input  metrics_type   push_entry,
   output logic          full,
   output logic          head_valid,
   output metrics_type   head_entry,
   input  logic          pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   metrics_type      store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = ctl_in.push && !ctl_in.full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/wrwd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrist raise wake detector decision stage
// Applies the running block, candidate window, stable count and cooldown.
// ----------------------------------------------------------------------------
module wrwd_back
   import wrwd_pkg::*;
#(
   parameter int REQUIRED_STABLE = REQUIRED_STABLE_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  head_valid,
   input  metrics_type           head_entry,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rsp_word_type          out_word
);

   localparam int CNT_W = $clog2(REQUIRED_STABLE + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(REQUIRED_STABLE);

   logic [17:0] run_accel_ff;
   logic [16:0] run_gyro_ff;
   logic [17:0] gest_accel_ff;
   logic [16:0] gest_gyro_ff;
   logic [17:0] gest_score_ff;
   logic [17:0] stable_accel_ff;
   logic [16:0] stable_gyro_ff;
   logic [15:0] cooldown_ff;

   logic             cand_ff, cand_in;
   logic [31:0]      deadline_ff, deadline_in;
   logic [31:0]      block_until_ff, block_until_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      last_wake_ff, last_wake_in;

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   logic [CNT_W+1:0] count_ext;

   assign pop       = head_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign count_ext = {2'b00, count_in};

   always_comb begin
      logic        running;
      logic        blocked;
      logic        start;
      logic        stable;
      logic        wake;
      logic [31:0] d_block;
      logic [31:0] d_dead;
      logic [31:0] d_wake;
      reason_type  reason;

      cand_in        = cand_ff;
      deadline_in    = deadline_ff;
      block_until_in = block_until_ff;
      count_in       = count_ff;
      last_wake_in   = last_wake_ff;
      reason         = REASON_NONE;
      wake           = 1'b0;
      running        = (head_entry.change >= run_accel_ff) || (head_entry.gsum >= run_gyro_ff);
      d_block        = head_entry.now - block_until_ff;
      blocked        = d_block[31];
      start          = !blocked && ((head_entry.change >= gest_accel_ff) ||
                                    (head_entry.gsum >= gest_gyro_ff) ||
                                    (head_entry.score >= gest_score_ff));
      d_dead         = '0;
      d_wake         = '0;
      stable         = 1'b0;

      if (!head_entry.armed) begin
         cand_in     = 1'b0;
         deadline_in = '0;
         count_in    = '0;
         reason      = REASON_DISARMED;
      end else if (running) begin
         block_until_in = head_entry.now + RUN_BLOCK_MS;
         cand_in        = 1'b0;
         deadline_in    = '0;
         count_in       = '0;
         reason         = REASON_RUNNING;
      end else begin
         if (start) begin
            cand_in     = 1'b1;
            deadline_in = head_entry.now + GESTURE_WINDOW_MS;
            count_in    = '0;
            reason      = REASON_CAND;
         end
         // The window has expired once now is strictly past the deadline.
         d_dead = head_entry.now - deadline_in;
         if (cand_in && !d_dead[31] && (d_dead != '0)) begin
            cand_in     = 1'b0;
            deadline_in = '0;
            count_in    = '0;
            reason      = REASON_EXPIRED;
         end
         stable = cand_in && !blocked && (head_entry.change <= stable_accel_ff) &&
                  (head_entry.gsum <= stable_gyro_ff);
         if (stable) begin
            if (count_in < CNT_MAX) begin
               count_in = count_in + 1'b1;
            end
         end else if (!blocked) begin
            count_in = '0;
         end
         d_wake = head_entry.now - last_wake_ff;
         if ((count_in >= CNT_MAX) && !d_wake[31] && (d_wake >= {16'h0000, cooldown_ff})) begin
            last_wake_in = head_entry.now;
            cand_in      = 1'b0;
            deadline_in  = '0;
            count_in     = '0;
            reason       = REASON_WOKE;
            wake         = 1'b1;
         end
      end

      out_word_in.wake             = wake;
      out_word_in.reason           = reason;
      out_word_in.accel_change     = head_entry.change;
      out_word_in.gyro_magnitude   = head_entry.gsum;
      out_word_in.activity_score   = head_entry.score;
      out_word_in.candidate_active = cand_in;
      out_word_in.stable_count     = count_ext[1:0];
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         cand_ff        <= 1'b0;
         deadline_ff    <= '0;
         block_until_ff <= '0;
         count_ff       <= '0;
         last_wake_ff   <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            cand_ff        <= cand_in;
            deadline_ff    <= deadline_in;
            block_until_ff <= block_until_in;
            count_ff       <= count_in;
            last_wake_ff   <= last_wake_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_word_ff <= out_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_accel_ff    <= RUN_ACCEL_RST;
         run_gyro_ff     <= RUN_GYRO_RST;
         gest_accel_ff   <= GEST_ACCEL_RST;
         gest_gyro_ff    <= GEST_GYRO_RST;
         gest_score_ff   <= GEST_SCORE_RST;
         stable_accel_ff <= STABLE_ACCEL_RST;
         stable_gyro_ff  <= STABLE_GYRO_RST;
         cooldown_ff     <= COOLDOWN_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_RUN_ACCEL:    run_accel_ff    <= csr_wdata;
            CSR_RUN_GYRO:     run_gyro_ff     <= csr_wdata[16:0];
            CSR_GEST_ACCEL:   gest_accel_ff   <= csr_wdata;
            CSR_GEST_GYRO:    gest_gyro_ff    <= csr_wdata[16:0];
            CSR_GEST_SCORE:   gest_score_ff   <= csr_wdata;
            CSR_STABLE_ACCEL: stable_accel_ff <= csr_wdata;
            CSR_STABLE_GYRO:  stable_gyro_ff  <= csr_wdata[16:0];
            CSR_COOLDOWN:     cooldown_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

endmodule

// File: hdl/wrist_raise_wake_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrist raise wake detector core
// Turns a stream of timestamped IMU samples into wake decisions.
// ----------------------------------------------------------------------------
// Usage:
// One sample word enters on the req_ stream and exactly one result word
// leaves on the rsp_ stream for it, in order. The front end computes the
// accel change, gyro sum and motion score as the word is accepted and pushes
// them into a four-entry queue; the decision stage pops one entry a cycle
// while the output register is free or being taken, updates the candidate,
// block and cooldown state and loads the output register.
// A sample is registered in the queue and its result in the output register
// before rsp_tvalid rises. Throughput is one word per cycle while rsp_tready
// stays high.
// When rsp_tready is low the output register holds its word; the queue keeps
// taking samples until its four entries are full, then req_tready drops.
// Reset empties the queue, clears rsp_tvalid and all detector state and
// loads the registers with their default thresholds. csr_ writes take effect
// at once; the user must make them while the block is idle, not enforced here.
// ----------------------------------------------------------------------------
module wrist_raise_wake_detector_core
   import wrwd_pkg::*;
#(
   parameter int REQUIRED_STABLE = REQUIRED_STABLE_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // armed, timestamp_ms, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // wake, reason, accel_change, gyro_magnitude, activity_score,
   // candidate_active, stable_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int REQ_W = $bits(req_word_type);
   localparam int RSP_W = $bits(rsp_word_type);

   req_word_type  in_word;
   rsp_word_type  out_word;
   metrics_type   push_entry;
   metrics_type   head_entry;
   queue_ctl_type q_ctl;
   logic          q_full;
   logic          q_push;
   logic          head_valid;
   logic          pop;

   assign in_word   = req_tdata[REQ_W-1:0];
   assign rsp_tdata = {{(RSP_DATA_W - RSP_W){1'b0}}, out_word};
   assign q_ctl.push = q_push;
   assign q_ctl.full = q_full;

   wrwd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_word  (in_word),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   wrwd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (q_ctl),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   wrwd_back #(
      .REQUIRED_STABLE (REQUIRED_STABLE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (out_word)
   );

endmodule

// File: hdl/wrwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrist raise wake detector checker
// Port-level properties of the detector core, bound to the top level.
// ----------------------------------------------------------------------------
module wrwd_checker
   import wrwd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_word_type rsp;

   assign rsp = rsp_tdata[$bits(rsp_word_type)-1:0];

   // A stalled result word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // A wake pulse is always reported as woke and closes the candidate.
   a_wake_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.wake |->
         rsp.reason == REASON_WOKE && !rsp.candidate_active && rsp.stable_count == 2'd0)
      else $error("wake without cleared candidate");

   // A disarmed sample reports nothing but its reason.
   a_disarmed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.reason == REASON_DISARMED |->
         !rsp.wake && rsp.accel_change == '0 && rsp.gyro_magnitude == '0 &&
         rsp.activity_score == '0 && !rsp.candidate_active && rsp.stable_count == 2'd0)
      else $error("disarmed result carries data");

   // Running motion always drops the candidate.
   a_running_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.reason == REASON_RUNNING |-> !rsp.candidate_active && !rsp.wake)
      else $error("candidate kept through running motion");

endmodule

bind wrist_raise_wake_detector_core wrwd_checker u_wrwd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
